// File: hdl/ipc_pkg.sv
// Shared types, constants and codes for the isotonic calibration block.
package ipc_pkg;

    localparam int BLOCKS    = 1024;
    localparam int FRAC_BITS = 15;
    localparam int IDX_W     = $clog2(BLOCKS);
    localparam int CNT_W     = IDX_W + 1;
    localparam int KEY_W     = 16;
    localparam int W_W       = 26;
    localparam int S_W       = 42;
    localparam int SW_W      = 32;
    localparam int Q_W       = 17;
    localparam int DCNT_W    = $clog2(Q_W);
    localparam int HALF_W    = 21;
    localparam int PP_W      = HALF_W + W_W;
    localparam int CMP_W     = S_W + W_W;

    localparam logic [W_W-1:0]   W_MAX = {W_W{1'b1}};
    localparam logic [KEY_W-1:0] ONE_Q = KEY_W'(32'd1 << FRAC_BITS);

    typedef enum logic [2:0] {
        ACT_ADD    = 3'd0,
        ACT_FINISH = 3'd1,
        ACT_READ   = 3'd2,
        ACT_QUERY  = 3'd3,
        ACT_CLEAR  = 3'd4
    } t_action;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_ORDER = 3'd1,
        ST_FULL  = 3'd2,
        ST_EMPTY = 3'd3,
        ST_INDEX = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        OP_ADD,
        OP_FINISH,
        OP_READ,
        OP_QUERY,
        OP_CLEAR,
        OP_NOP
    } t_op;

    typedef enum logic [4:0] {
        S_IDLE,
        S_EXEC,
        S_PUSH_CHK,
        S_PUSH_LD,
        S_MUL_LO,
        S_MUL_HI,
        S_CMP,
        S_PUSH_WR,
        S_FIN_START,
        S_FIN_LD,
        S_DIV,
        S_FIN_MUL,
        S_FIN_WR,
        S_Q_CHK,
        S_Q_CMP,
        S_RD,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [2:0]  action;
        logic [15:0] key;
        logic [15:0] score;
        logic [15:0] sample_weight;
        logic [9:0]  entry_number;
    } t_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] edge_res;
        logic [15:0] probability;
        logic [25:0] total_weight;
        logic [10:0] entry_count;
    } t_out;

    typedef struct packed {
        t_op              op;
        logic [KEY_W-1:0] key;
        logic [SW_W-1:0]  sw;
        logic [15:0]      w;
        logic [9:0]       entry;
    } t_cmd;

endpackage

// File: hdl/ipc_front.sv
// Request decode and two-entry command queue in front of the engine.
module ipc_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  ipc_pkg::t_in  i_data,
    output logic          o_cmd_valid,
    input  logic          i_cmd_pop,
    output ipc_pkg::t_cmd o_cmd
);

    ipc_pkg::t_cmd              w_cmd;
    logic [ipc_pkg::KEY_W-1:0]  w_score;
    ipc_pkg::t_cmd              r_q [2];
    logic                       r_wp;
    logic                       r_rp;
    logic [1:0]                 r_cnt;
    logic                       w_push;

    always_comb begin
        w_score = (i_data.score > ipc_pkg::ONE_Q) ? ipc_pkg::ONE_Q : i_data.score;
        w_cmd.key   = i_data.key;
        w_cmd.w     = i_data.sample_weight;
        w_cmd.entry = i_data.entry_number;
        w_cmd.sw    = {16'd0, w_score} * {16'd0, i_data.sample_weight};
        unique case (i_data.action)
            ipc_pkg::ACT_ADD: begin
                // zero weight adds do nothing
                w_cmd.op = (i_data.sample_weight == 16'd0) ? ipc_pkg::OP_NOP
                                                           : ipc_pkg::OP_ADD;
            end
            ipc_pkg::ACT_FINISH: w_cmd.op = ipc_pkg::OP_FINISH;
            ipc_pkg::ACT_READ:   w_cmd.op = ipc_pkg::OP_READ;
            ipc_pkg::ACT_QUERY:  w_cmd.op = ipc_pkg::OP_QUERY;
            ipc_pkg::ACT_CLEAR:  w_cmd.op = ipc_pkg::OP_CLEAR;
            default:             w_cmd.op = ipc_pkg::OP_NOP;
        endcase
    end

    assign o_ready     = (r_cnt != 2'd2);
    assign w_push      = i_valid && o_ready;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (i_cmd_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, i_cmd_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
    end

endmodule

// File: hdl/ipc_back.sv
// Engine: block stack with pooling, table build, lookup and result register.
module ipc_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    output logic          o_cmd_pop,
    input  ipc_pkg::t_cmd i_cmd,
    output logic          o_valid,
    input  logic          i_ready,
    output ipc_pkg::t_out o_data
);

    localparam int IW = ipc_pkg::IDX_W;
    localparam int CW = ipc_pkg::CNT_W;
    localparam int KW = ipc_pkg::KEY_W;
    localparam int WW = ipc_pkg::W_W;
    localparam int SW = ipc_pkg::S_W;
    localparam int QW = ipc_pkg::Q_W;
    localparam int HW = ipc_pkg::HALF_W;
    localparam int PW = ipc_pkg::PP_W;
    localparam int XW = ipc_pkg::CMP_W;

    ipc_pkg::t_state r_state, n_state;
    ipc_pkg::t_cmd   r_cmd, n_cmd;

    logic [CW-1:0] r_top, n_top;
    logic [KW-1:0] r_pkey, n_pkey;
    logic [WW-1:0] r_pw, n_pw;
    logic [SW-1:0] r_ps, n_ps;
    logic          r_pv, n_pv;
    logic          r_ready, n_ready;
    logic [WW-1:0] r_total, n_total;

    logic [CW-1:0] r_t, n_t;
    logic          r_need_room, n_need_room;
    logic          r_fin_mode, n_fin_mode;
    logic [KW-1:0] r_cf, n_cf;
    logic [KW-1:0] r_cl, n_cl;
    logic [WW-1:0] r_cw, n_cw;
    logic [SW-1:0] r_cs, n_cs;
    logic [KW-1:0] r_bf, n_bf;
    logic [WW-1:0] r_bw, n_bw;
    logic [SW-1:0] r_bs, n_bs;
    logic [PW-1:0] r_p1lo, n_p1lo, r_p2lo, n_p2lo, r_p1hi, n_p1hi, r_p2hi, n_p2hi;

    logic [IW-1:0] r_raddr, n_raddr;
    logic [IW-1:0] r_c, n_c;
    logic [IW-1:0] r_lo, n_lo, r_hi, n_hi;

    logic [QW-1:0]               r_num, n_num;
    logic [WW-1:0]               r_rem, n_rem;
    logic [WW-1:0]               r_dd, n_dd;
    logic [QW-1:0]               r_q, n_q;
    logic [ipc_pkg::DCNT_W-1:0]  r_dcnt, n_dcnt;
    logic                        r_div_edge, n_div_edge;
    logic [15:0]                 r_pq, n_pq;
    logic [KW-1:0]               r_fe, n_fe;

    ipc_pkg::t_status r_status, n_status;
    logic [15:0]      r_edge, n_edge;
    logic [15:0]      r_prob, n_prob;
    logic [WW-1:0]    r_tw, n_tw;
    ipc_pkg::t_out    r_out, n_out;
    logic             r_out_v, n_out_v;

    logic w_blk_we, w_tbl_we;

    logic [KW-1:0] m_first [ipc_pkg::BLOCKS];
    logic [KW-1:0] m_last  [ipc_pkg::BLOCKS];
    logic [WW-1:0] m_w     [ipc_pkg::BLOCKS];
    logic [SW-1:0] m_s     [ipc_pkg::BLOCKS];
    logic [KW-1:0] m_edge  [ipc_pkg::BLOCKS];
    logic [15:0]   m_prob  [ipc_pkg::BLOCKS];

    logic [KW-1:0] rd_first, rd_last, rd_edge;
    logic [WW-1:0] rd_w;
    logic [SW-1:0] rd_s;
    logic [15:0]   rd_prob;

    // shared conditions
    logic          w_key_lt, w_key_eq, w_over, w_tight, w_ge, w_last_c;
    logic [WW:0]   w_sum_w;
    logic [XW-1:0] w_a, w_b;
    logic [WW:0]   w_div_t;
    logic          w_div_ge, w_div_end;
    logic [QW-1:0] w_q_fin;
    logic [KW-1:0] w_d;
    logic [IW:0]   w_mid;
    logic          w_out_free;

    assign w_key_lt  = r_cmd.key < r_pkey;
    assign w_key_eq  = r_cmd.key == r_pkey;
    assign w_sum_w   = {1'b0, r_total} + (WW+1)'(r_cmd.w);
    assign w_over    = w_sum_w > {1'b0, ipc_pkg::W_MAX};
    assign w_tight   = r_top >= CW'(ipc_pkg::BLOCKS - 1);
    assign w_a       = (XW'(r_p1hi) << HW) + XW'(r_p1lo);
    assign w_b       = (XW'(r_p2hi) << HW) + XW'(r_p2lo);
    assign w_ge      = w_a >= w_b;
    assign w_last_c  = ({1'b0, r_c} + CW'(1)) >= r_top;
    assign w_div_t   = {r_rem, r_num[QW-1]};
    assign w_div_ge  = w_div_t >= {1'b0, r_dd};
    assign w_div_end = r_dcnt == ipc_pkg::DCNT_W'(QW - 1);
    assign w_q_fin   = {r_q[QW-2:0], w_div_ge};
    assign w_d       = (rd_first > r_cl) ? rd_first - r_cl : '0;
    assign w_mid     = ({1'b0, r_lo} + {1'b0, r_hi}) >> 1;
    assign w_out_free = !r_out_v || i_ready;

    assign o_valid = r_out_v;
    assign o_data  = r_out;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ipc_pkg::S_IDLE: begin
                if (i_cmd_valid) begin
                    n_state = ipc_pkg::S_EXEC;
                end
            end
            ipc_pkg::S_EXEC: begin
                unique case (r_cmd.op)
                    ipc_pkg::OP_ADD: begin
                        if (!r_ready && r_pv && !w_key_lt && !w_over && !w_key_eq) begin
                            n_state = ipc_pkg::S_PUSH_CHK;
                        end else begin
                            n_state = ipc_pkg::S_DONE;
                        end
                    end
                    ipc_pkg::OP_FINISH: begin
                        n_state = r_pv ? ipc_pkg::S_PUSH_CHK : ipc_pkg::S_FIN_START;
                    end
                    ipc_pkg::OP_READ: begin
                        if (r_ready && ({1'b0, r_cmd.entry} < r_top)) begin
                            n_state = ipc_pkg::S_RD;
                        end else begin
                            n_state = ipc_pkg::S_DONE;
                        end
                    end
                    ipc_pkg::OP_QUERY: begin
                        n_state = r_ready ? ipc_pkg::S_Q_CHK : ipc_pkg::S_DONE;
                    end
                    default: n_state = ipc_pkg::S_DONE;
                endcase
            end
            ipc_pkg::S_PUSH_CHK: begin
                n_state = (r_t == '0) ? ipc_pkg::S_PUSH_WR : ipc_pkg::S_PUSH_LD;
            end
            ipc_pkg::S_PUSH_LD: n_state = ipc_pkg::S_MUL_LO;
            ipc_pkg::S_MUL_LO:  n_state = ipc_pkg::S_MUL_HI;
            ipc_pkg::S_MUL_HI:  n_state = ipc_pkg::S_CMP;
            ipc_pkg::S_CMP: begin
                priority if (w_ge) begin
                    n_state = ipc_pkg::S_PUSH_CHK;
                end else if (r_need_room) begin
                    n_state = ipc_pkg::S_DONE;
                end else begin
                    n_state = ipc_pkg::S_PUSH_WR;
                end
            end
            ipc_pkg::S_PUSH_WR: begin
                n_state = r_fin_mode ? ipc_pkg::S_FIN_START : ipc_pkg::S_DONE;
            end
            ipc_pkg::S_FIN_START: begin
                n_state = (r_top == '0) ? ipc_pkg::S_DONE : ipc_pkg::S_FIN_LD;
            end
            ipc_pkg::S_FIN_LD: n_state = ipc_pkg::S_DIV;
            ipc_pkg::S_DIV: begin
                if (w_div_end) begin
                    if (r_div_edge || w_last_c) begin
                        n_state = ipc_pkg::S_FIN_WR;
                    end else begin
                        n_state = ipc_pkg::S_FIN_MUL;
                    end
                end
            end
            ipc_pkg::S_FIN_MUL: n_state = ipc_pkg::S_DIV;
            ipc_pkg::S_FIN_WR: begin
                n_state = w_last_c ? ipc_pkg::S_DONE : ipc_pkg::S_FIN_LD;
            end
            ipc_pkg::S_Q_CHK: begin
                n_state = (r_lo == r_hi) ? ipc_pkg::S_RD : ipc_pkg::S_Q_CMP;
            end
            ipc_pkg::S_Q_CMP: n_state = ipc_pkg::S_Q_CHK;
            ipc_pkg::S_RD:    n_state = ipc_pkg::S_DONE;
            ipc_pkg::S_DONE: begin
                if (w_out_free) begin
                    n_state = ipc_pkg::S_IDLE;
                end
            end
            default: n_state = ipc_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_cmd = r_cmd;   n_top = r_top;   n_pkey = r_pkey; n_pw = r_pw;
        n_ps = r_ps;     n_pv = r_pv;     n_ready = r_ready; n_total = r_total;
        n_t = r_t;       n_need_room = r_need_room; n_fin_mode = r_fin_mode;
        n_cf = r_cf;     n_cl = r_cl;     n_cw = r_cw;     n_cs = r_cs;
        n_bf = r_bf;     n_bw = r_bw;     n_bs = r_bs;
        n_p1lo = r_p1lo; n_p2lo = r_p2lo; n_p1hi = r_p1hi; n_p2hi = r_p2hi;
        n_raddr = r_raddr; n_c = r_c;     n_lo = r_lo;     n_hi = r_hi;
        n_num = r_num;   n_rem = r_rem;   n_dd = r_dd;     n_q = r_q;
        n_dcnt = r_dcnt; n_div_edge = r_div_edge; n_pq = r_pq; n_fe = r_fe;
        n_status = r_status; n_edge = r_edge; n_prob = r_prob; n_tw = r_tw;
        n_out = r_out;
        n_out_v = r_out_v && !i_ready;
        o_cmd_pop = 1'b0;
        w_blk_we  = 1'b0;
        w_tbl_we  = 1'b0;
        unique case (r_state)
            ipc_pkg::S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_cmd = i_cmd;
                end
            end
            ipc_pkg::S_EXEC: begin
                n_status = ipc_pkg::ST_OK;
                n_edge = '0;
                n_prob = '0;
                n_tw   = '0;
                n_cf = r_pkey;
                n_cl = r_pkey;
                n_cw = r_pw;
                n_cs = r_ps;
                n_t  = r_top;
                unique case (r_cmd.op)
                    ipc_pkg::OP_ADD: begin
                        n_fin_mode  = 1'b0;
                        n_need_room = w_tight;
                        priority if (r_ready) begin
                            // start a fresh collection with this sample
                            n_ready = 1'b0;
                            n_top   = '0;
                            n_pkey  = r_cmd.key;
                            n_pw    = WW'(r_cmd.w);
                            n_ps    = SW'(r_cmd.sw);
                            n_pv    = 1'b1;
                            n_total = WW'(r_cmd.w);
                        end else if (r_pv && w_key_lt) begin
                            n_status = ipc_pkg::ST_ORDER;
                        end else if (w_over) begin
                            n_status = ipc_pkg::ST_FULL;
                        end else if (r_pv && w_key_eq) begin
                            n_pw    = r_pw + WW'(r_cmd.w);
                            n_ps    = r_ps + SW'(r_cmd.sw);
                            n_total = w_sum_w[WW-1:0];
                        end else if (r_pv) begin
                            n_status = ipc_pkg::ST_OK;
                        end else if (r_top >= CW'(ipc_pkg::BLOCKS)) begin
                            n_status = ipc_pkg::ST_FULL;
                        end else begin
                            n_pkey  = r_cmd.key;
                            n_pw    = WW'(r_cmd.w);
                            n_ps    = SW'(r_cmd.sw);
                            n_pv    = 1'b1;
                            n_total = w_sum_w[WW-1:0];
                        end
                    end
                    ipc_pkg::OP_FINISH: begin
                        n_fin_mode  = 1'b1;
                        n_need_room = 1'b0;
                    end
                    ipc_pkg::OP_READ: begin
                        priority if (!r_ready) begin
                            n_status = ipc_pkg::ST_EMPTY;
                        end else if ({1'b0, r_cmd.entry} >= r_top) begin
                            n_status = ipc_pkg::ST_INDEX;
                        end else begin
                            n_raddr = r_cmd.entry;
                        end
                    end
                    ipc_pkg::OP_QUERY: begin
                        if (!r_ready) begin
                            n_status = ipc_pkg::ST_EMPTY;
                        end
                        n_lo = '0;
                        n_hi = IW'(r_top - CW'(1));
                    end
                    ipc_pkg::OP_CLEAR: begin
                        n_top = '0; n_pkey = '0; n_pw = '0; n_ps = '0;
                        n_pv = 1'b0; n_ready = 1'b0; n_total = '0;
                    end
                    default: begin
                    end
                endcase
            end
            ipc_pkg::S_PUSH_CHK: begin
                if (r_t != '0) begin
                    n_raddr = IW'(r_t - CW'(1));
                end
            end
            ipc_pkg::S_PUSH_LD: begin
                n_bf = rd_first;
                n_bw = rd_w;
                n_bs = rd_s;
            end
            ipc_pkg::S_MUL_LO: begin
                n_p1lo = PW'(r_bs[HW-1:0]) * PW'(r_cw);
                n_p2lo = PW'(r_cs[HW-1:0]) * PW'(r_bw);
            end
            ipc_pkg::S_MUL_HI: begin
                n_p1hi = PW'(r_bs[SW-1:HW]) * PW'(r_cw);
                n_p2hi = PW'(r_cs[SW-1:HW]) * PW'(r_bw);
            end
            ipc_pkg::S_CMP: begin
                priority if (w_ge) begin
                    // pool the block below into the current one
                    n_cf = r_bf;
                    n_cw = r_cw + r_bw;
                    n_cs = r_cs + r_bs;
                    n_t  = r_t - CW'(1);
                    n_need_room = 1'b0;
                end else if (r_need_room) begin
                    n_status = ipc_pkg::ST_FULL;
                end else begin
                    n_status = ipc_pkg::ST_OK;
                end
            end
            ipc_pkg::S_PUSH_WR: begin
                w_blk_we = 1'b1;
                n_top = r_t + CW'(1);
                n_pv  = 1'b0;
                if (!r_fin_mode) begin
                    n_pkey  = r_cmd.key;
                    n_pw    = WW'(r_cmd.w);
                    n_ps    = SW'(r_cmd.sw);
                    n_pv    = 1'b1;
                    n_total = w_sum_w[WW-1:0];
                end
            end
            ipc_pkg::S_FIN_START: begin
                if (r_top == '0) begin
                    n_status = ipc_pkg::ST_EMPTY;
                end
                n_raddr = '0;
                n_c     = '0;
            end
            ipc_pkg::S_FIN_LD: begin
                n_cf = rd_first;
                n_cl = rd_last;
                n_cw = rd_w;
                if (!w_last_c) begin
                    n_raddr = r_c + IW'(1);
                end
                n_rem = WW'(rd_s >> QW);
                n_num = rd_s[QW-1:0];
                n_dd  = rd_w;
                n_q   = '0;
                n_dcnt = '0;
                n_div_edge = 1'b0;
            end
            ipc_pkg::S_DIV: begin
                n_rem  = w_div_ge ? WW'(w_div_t - {1'b0, r_dd}) : WW'(w_div_t);
                n_num  = {r_num[QW-2:0], 1'b0};
                n_q    = w_q_fin;
                n_dcnt = r_dcnt + ipc_pkg::DCNT_W'(1);
                if (w_div_end) begin
                    if (r_div_edge) begin
                        n_fe = r_cl + w_q_fin[KW-1:0];
                    end else begin
                        n_pq = w_q_fin[15:0];
                        n_fe = r_cf;
                    end
                end
            end
            ipc_pkg::S_FIN_MUL: begin
                // numerator gap * weight, denominator summed weight of the pair
                {n_rem, n_num} = (WW + QW)'(SW'(w_d) * SW'(r_cw)) >> 0;
                n_rem = WW'((SW'(w_d) * SW'(r_cw)) >> QW);
                n_num = QW'(SW'(w_d) * SW'(r_cw));
                n_dd  = r_cw + rd_w;
                n_q   = '0;
                n_dcnt = '0;
                n_div_edge = 1'b1;
            end
            ipc_pkg::S_FIN_WR: begin
                w_tbl_we = 1'b1;
                if (w_last_c) begin
                    n_ready  = 1'b1;
                    n_status = ipc_pkg::ST_OK;
                end else begin
                    n_c = r_c + IW'(1);
                end
            end
            ipc_pkg::S_Q_CHK: begin
                if (r_lo == r_hi) begin
                    n_raddr = r_lo;
                end else begin
                    n_raddr = w_mid[IW-1:0];
                end
            end
            ipc_pkg::S_Q_CMP: begin
                if (rd_edge >= r_cmd.key) begin
                    n_hi = r_raddr;
                end else begin
                    n_lo = r_raddr + IW'(1);
                end
            end
            ipc_pkg::S_RD: begin
                n_edge = rd_edge;
                n_prob = rd_prob;
                n_tw   = rd_w;
            end
            ipc_pkg::S_DONE: begin
                if (w_out_free) begin
                    n_out.status       = r_status;
                    n_out.edge_res     = r_edge;
                    n_out.probability  = r_prob;
                    n_out.total_weight = r_tw;
                    n_out.entry_count  = r_ready ? r_top : '0;
                    n_out_v = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ipc_pkg::S_IDLE;
            r_top   <= '0;
            r_pkey  <= '0;
            r_pw    <= '0;
            r_ps    <= '0;
            r_pv    <= 1'b0;
            r_ready <= 1'b0;
            r_total <= '0;
            r_out_v <= 1'b0;
        end else begin
            r_state <= n_state;
            r_top   <= n_top;
            r_pkey  <= n_pkey;
            r_pw    <= n_pw;
            r_ps    <= n_ps;
            r_pv    <= n_pv;
            r_ready <= n_ready;
            r_total <= n_total;
            r_out_v <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;  r_t <= n_t;  r_need_room <= n_need_room;
        r_fin_mode <= n_fin_mode;
        r_cf <= n_cf;  r_cl <= n_cl;  r_cw <= n_cw;  r_cs <= n_cs;
        r_bf <= n_bf;  r_bw <= n_bw;  r_bs <= n_bs;
        r_p1lo <= n_p1lo;  r_p2lo <= n_p2lo;  r_p1hi <= n_p1hi;  r_p2hi <= n_p2hi;
        r_raddr <= n_raddr;  r_c <= n_c;  r_lo <= n_lo;  r_hi <= n_hi;
        r_num <= n_num;  r_rem <= n_rem;  r_dd <= n_dd;  r_q <= n_q;
        r_dcnt <= n_dcnt;  r_div_edge <= n_div_edge;  r_pq <= n_pq;  r_fe <= n_fe;
        r_status <= n_status;  r_edge <= n_edge;  r_prob <= n_prob;  r_tw <= n_tw;
        r_out <= n_out;
    end

    // block stack and table memories, read data registered
    always_ff @(posedge i_clk) begin
        if (w_blk_we) begin
            m_first[r_t[IW-1:0]] <= r_cf;
            m_last[r_t[IW-1:0]]  <= r_cl;
            m_w[r_t[IW-1:0]]     <= r_cw;
            m_s[r_t[IW-1:0]]     <= r_cs;
        end
        rd_first <= m_first[n_raddr];
        rd_last  <= m_last[n_raddr];
        rd_w     <= m_w[n_raddr];
        rd_s     <= m_s[n_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_tbl_we) begin
            m_edge[r_c] <= r_fe;
            m_prob[r_c] <= r_pq;
        end
        rd_edge <= m_edge[n_raddr];
        rd_prob <= m_prob[n_raddr];
    end

`ifndef SYNTHESIS
    a_top_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_top <= CW'(ipc_pkg::BLOCKS))
        else $error("stack depth beyond capacity");

    a_ready_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ready |-> (r_top != '0))
        else $error("table ready with no entries");

    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ipc_pkg::S_DIV) |-> (r_rem < r_dd))
        else $error("divider remainder not below divisor");

    a_push_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ipc_pkg::S_PUSH_WR) |-> (r_t < CW'(ipc_pkg::BLOCKS)))
        else $error("push beyond last stack slot");

    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ipc_pkg::S_DONE && w_out_free) |=> r_out_v)
        else $error("result not presented after completion");
`endif

endmodule

// File: hdl/isotonic_probability_calibration_core.sv
// Isotonic calibration table builder: add, finish, read, query, clear.
// Requests enter a two-entry queue and run one at a time in the engine;
// results leave through a registered output stage. An add that starts or
// extends the pending sample leaves the block stack alone; an add with a new
// key pools the pending sample with the blocks below while their mean is not
// lower, then writes it to the stack, each pool step being one stack read and
// a cross-multiplied mean compare from low and high partial products. Finish
// runs the one-bit-per-cycle divider (17 steps) twice per table entry, once
// for the last. A query is a binary search over the edge memory. Memories
// are not cleared; no reset sweep is needed.
module isotonic_probability_calibration_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  ipc_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output ipc_pkg::t_out o_data
);

    logic          w_cmd_valid;
    logic          w_cmd_pop;
    ipc_pkg::t_cmd w_cmd;

    ipc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data      (i_data),
        .o_cmd_valid (w_cmd_valid),
        .i_cmd_pop   (w_cmd_pop),
        .o_cmd       (w_cmd)
    );

    ipc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .o_cmd_pop   (w_cmd_pop),
        .i_cmd       (w_cmd),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data)
    );

endmodule

// File: verif/tb_isotonic_probability_calibration_core.sv
// Testbench for the isotonic calibration core: directed, capacity and random request streams.
`timescale 1ns / 1ps

module tb_isotonic_probability_calibration_core;

    localparam int  CYCLE_LIMIT = 1500000;
    localparam int  RANDOM_ITEMS = 380;
    localparam int  DRAIN_CYCLES = 100;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_ready = 1'b0;
    ipc_pkg::t_in  i_data = '0;
    logic o_ready;
    logic o_valid;
    ipc_pkg::t_out o_data;

    ipc_pkg::t_out calib_expected[$];
    int          mismatch_count = 0;
    int          sent_count = 0;
    int          cycle_count = 0;
    bit          calm = 1'b0;

    // Predictor state
    logic [15:0] blk_first_key[ipc_pkg::BLOCKS];
    logic [15:0] blk_last_key[ipc_pkg::BLOCKS];
    logic [25:0] blk_weight[ipc_pkg::BLOCKS];
    logic [41:0] blk_score_sum[ipc_pkg::BLOCKS];
    logic [15:0] tbl_edge[ipc_pkg::BLOCKS];
    logic [15:0] tbl_prob[ipc_pkg::BLOCKS];
    int unsigned blk_top;
    logic [15:0] pend_key;
    logic [25:0] pend_weight;
    logic [41:0] pend_score_sum;
    bit          pend_valid;
    bit          tbl_ready;
    int unsigned weight_sum;

    isotonic_probability_calibration_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic void calib_clear();
        for (int i = 0; i < ipc_pkg::BLOCKS; i++) begin
            blk_first_key[i] = '0;
            blk_last_key[i] = '0;
            blk_weight[i] = '0;
            blk_score_sum[i] = '0;
            tbl_edge[i] = '0;
            tbl_prob[i] = '0;
        end
        blk_top = 0;
        pend_key = '0;
        pend_weight = '0;
        pend_score_sum = '0;
        pend_valid = 1'b0;
        tbl_ready = 1'b0;
        weight_sum = 0;
    endfunction

    // True when mean s1/w1 is not below s2/w2, compared by cross products.
    function automatic bit mean_not_lower(logic [41:0] s1, logic [25:0] w1,
                                          logic [41:0] s2, logic [25:0] w2);
        logic [127:0] lhs;
        logic [127:0] rhs;
        lhs = 128'(s1) * 128'(w2);
        rhs = 128'(s2) * 128'(w1);
        return lhs >= rhs;
    endfunction

    function automatic void push_and_pool();
        int unsigned lo;
        if (!pend_valid || blk_top >= ipc_pkg::BLOCKS) return;
        blk_first_key[blk_top] = pend_key;
        blk_last_key[blk_top] = pend_key;
        blk_weight[blk_top] = pend_weight;
        blk_score_sum[blk_top] = pend_score_sum;
        blk_top++;
        pend_valid = 1'b0;
        while (blk_top >= 2 && mean_not_lower(blk_score_sum[blk_top-2], blk_weight[blk_top-2],
                                              blk_score_sum[blk_top-1], blk_weight[blk_top-1]))
        begin
            lo = blk_top - 2;
            blk_weight[lo] += blk_weight[lo+1];
            blk_score_sum[lo] += blk_score_sum[lo+1];
            blk_last_key[lo] = blk_last_key[lo+1];
            blk_top--;
        end
    endfunction

    function automatic logic [2:0] add_sample(logic [15:0] key, logic [15:0] score,
                                              logic [15:0] w);
        logic [15:0] sat;
        bit          room;
        if (w == 0) return ipc_pkg::ST_OK;
        if (tbl_ready) calib_clear();
        sat = (score > ipc_pkg::ONE_Q) ? ipc_pkg::ONE_Q : score;
        if (pend_valid && key < pend_key) return ipc_pkg::ST_ORDER;
        if (!pend_valid && blk_top > 0 && key <= blk_last_key[blk_top-1])
            return ipc_pkg::ST_ORDER;
        if (weight_sum + w > ipc_pkg::W_MAX) return ipc_pkg::ST_FULL;
        if (pend_valid && key == pend_key) begin
            pend_weight += w;
            pend_score_sum += 42'(sat) * 42'(w);
            weight_sum += w;
            return ipc_pkg::ST_OK;
        end
        if (pend_valid) begin
            room = (blk_top + 1 < ipc_pkg::BLOCKS) ||
                   (blk_top > 0 && mean_not_lower(blk_score_sum[blk_top-1],
                                                  blk_weight[blk_top-1],
                                                  pend_score_sum, pend_weight));
            if (!room) return ipc_pkg::ST_FULL;
            push_and_pool();
        end else if (blk_top >= ipc_pkg::BLOCKS) begin
            return ipc_pkg::ST_FULL;
        end
        pend_key = key;
        pend_weight = 26'(w);
        pend_score_sum = 42'(sat) * 42'(w);
        pend_valid = 1'b1;
        weight_sum += w;
        return ipc_pkg::ST_OK;
    endfunction

    function automatic logic [2:0] build_table();
        longint unsigned a, b, d, den;
        push_and_pool();
        if (blk_top == 0) return ipc_pkg::ST_EMPTY;
        for (int unsigned c = 0; c < blk_top; c++) begin
            tbl_prob[c] = 16'(blk_score_sum[c] / blk_weight[c]);
            if (c + 1 < blk_top) begin
                a = blk_last_key[c];
                b = blk_first_key[c+1];
                d = (b > a) ? b - a : 0;
                den = blk_weight[c] + blk_weight[c+1];
                tbl_edge[c] = 16'(a + d * blk_weight[c] / den);
            end else begin
                tbl_edge[c] = blk_first_key[c];
            end
        end
        tbl_ready = 1'b1;
        return ipc_pkg::ST_OK;
    endfunction

    function automatic ipc_pkg::t_out calib_predict(ipc_pkg::t_in req);
        ipc_pkg::t_out res;
        int unsigned   idx;
        res = '0;
        case (req.action)
            ipc_pkg::ACT_ADD: begin
                res.status = add_sample(req.key, req.score, req.sample_weight);
            end
            ipc_pkg::ACT_FINISH: begin
                res.status = build_table();
            end
            ipc_pkg::ACT_READ, ipc_pkg::ACT_QUERY: begin
                if (!tbl_ready || blk_top == 0) begin
                    res.status = ipc_pkg::ST_EMPTY;
                end else begin
                    idx = blk_top - 1;
                    if (req.action == ipc_pkg::ACT_READ) begin
                        idx = req.entry_number;
                        if (idx >= blk_top) res.status = ipc_pkg::ST_INDEX;
                    end else begin
                        for (int unsigned c = 0; c < blk_top; c++) begin
                            if (tbl_edge[c] >= req.key) begin
                                idx = c;
                                break;
                            end
                        end
                    end
                    if (res.status == ipc_pkg::ST_OK) begin
                        res.edge_res = tbl_edge[idx];
                        res.probability = tbl_prob[idx];
                        res.total_weight = blk_weight[idx];
                    end
                end
            end
            ipc_pkg::ACT_CLEAR: begin
                calib_clear();
            end
            default: ;
        endcase
        res.entry_count = tbl_ready ? 11'(blk_top) : '0;
        return res;
    endfunction

    task automatic send_request(input logic [2:0] act, input logic [15:0] key,
                                input logic [15:0] score, input logic [15:0] w,
                                input logic [9:0] entry);
        ipc_pkg::t_in req;
        req.action = act;
        req.key = key;
        req.score = score;
        req.sample_weight = w;
        req.entry_number = entry;
        i_data <= req;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
        calib_expected.push_back(calib_predict(req));
        sent_count++;
        if (!calm && $urandom_range(99) < 34) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
    endtask

    // Receiver stall
    always @(posedge i_clk) begin
        i_ready <= calm ? 1'b1 : ($urandom_range(99) >= 34);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Compare each result with the oldest prediction
    always @(posedge i_clk) begin
        ipc_pkg::t_out want;
        if (i_rst_n && o_valid && i_ready) begin
            if (calib_expected.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: %h", o_data);
            end else begin
                want = calib_expected.pop_front();
                if (o_data !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"mismatch: exp st=%0d edge=%0d prob=%0d tw=%0d cnt=%0d",
                                  " | act st=%0d edge=%0d prob=%0d tw=%0d cnt=%0d"},
                                 want.status, want.edge_res, want.probability,
                                 want.total_weight, want.entry_count,
                                 o_data.status, o_data.edge_res, o_data.probability,
                                 o_data.total_weight, o_data.entry_count);
                end
            end
        end
    end

    task automatic test_directed();
        send_request(ipc_pkg::ACT_READ, 16'd0, 16'd0, 16'd1, 10'd0);      // read before finish
        send_request(ipc_pkg::ACT_QUERY, 16'd100, 16'd0, 16'd1, 10'd0);   // query before finish
        send_request(ipc_pkg::ACT_FINISH, 16'd0, 16'd0, 16'd1, 10'd0);    // finish, no samples
        send_request(ipc_pkg::ACT_ADD, 16'd0, 16'd0, 16'd0, 10'd0);       // zero weight ignored
        send_request(ipc_pkg::ACT_ADD, 16'd0, 16'd30000, 16'd3, 10'd0);
        send_request(ipc_pkg::ACT_ADD, 16'd0, 16'hFFFF, 16'd2, 10'd0);    // score saturates
        send_request(ipc_pkg::ACT_ADD, 16'd1000, 16'd1000, 16'd5, 10'd0); // pooled by a later add
        send_request(ipc_pkg::ACT_ADD, 16'd500, 16'd1000, 16'd5, 10'd0);  // key out of order
        send_request(ipc_pkg::ACT_ADD, 16'd2000, 16'd20000, 16'hFFFF, 10'd0);
        send_request(ipc_pkg::ACT_ADD, 16'd32768, 16'd32768, 16'd7, 10'd0);
        send_request(3'd5, 16'hFFFF, 16'hFFFF, 16'hFFFF, 10'h3FF);
        send_request(ipc_pkg::ACT_FINISH, 16'd0, 16'd0, 16'd1, 10'd0);
        send_request(ipc_pkg::ACT_READ, 16'd0, 16'd0, 16'd1, 10'd0);
        send_request(ipc_pkg::ACT_READ, 16'd0, 16'd0, 16'd1, 10'd1);
        send_request(ipc_pkg::ACT_READ, 16'd0, 16'd0, 16'd1, 10'd2);
        send_request(ipc_pkg::ACT_READ, 16'd0, 16'd0, 16'd1, 10'h3FF);    // bad index
        send_request(ipc_pkg::ACT_QUERY, 16'd0, 16'd0, 16'd1, 10'd0);
        send_request(ipc_pkg::ACT_QUERY, 16'd32768, 16'd0, 16'd1, 10'd0);
        send_request(ipc_pkg::ACT_QUERY, 16'hFFFF, 16'd0, 16'd1, 10'd0);  // past last edge
        send_request(3'd7, 16'd0, 16'd0, 16'd0, 10'd0);
        send_request(ipc_pkg::ACT_ADD, 16'd10, 16'd5, 16'd1, 10'd0);      // add after finish
        send_request(ipc_pkg::ACT_READ, 16'd0, 16'd0, 16'd1, 10'd0);
        send_request(ipc_pkg::ACT_CLEAR, 16'd0, 16'd0, 16'd1, 10'd0);
        send_request(3'd6, 16'd0, 16'd0, 16'd1, 10'd0);
    endtask

    // Fill the block stack with strictly rising means, then hit stack full and weight overflow
    task automatic test_capacity();
        calm = 1'b1;
        for (int i = 0; i < ipc_pkg::BLOCKS; i++)
            send_request(ipc_pkg::ACT_ADD, 16'(i * 32), 16'(i * 32), 16'hFFFF, 10'd0);
        calm = 1'b0;
        send_request(ipc_pkg::ACT_ADD, 16'd32768, 16'd32768, 16'd1, 10'd0);
        send_request(ipc_pkg::ACT_ADD, 16'(1023 * 32), 16'd32768, 16'd1023, 10'd0);
        send_request(ipc_pkg::ACT_ADD, 16'(1023 * 32), 16'd32768, 16'd1, 10'd0);
        send_request(ipc_pkg::ACT_FINISH, 16'd0, 16'd0, 16'd1, 10'd0);
        send_request(ipc_pkg::ACT_READ, 16'd0, 16'd0, 16'd1, 10'd1023);
        send_request(ipc_pkg::ACT_READ, 16'd0, 16'd0, 16'd1, 10'd0);
        send_request(ipc_pkg::ACT_QUERY, 16'd16000, 16'd0, 16'd1, 10'd0);
        send_request(ipc_pkg::ACT_QUERY, 16'd32768, 16'd0, 16'd1, 10'd0);
        send_request(ipc_pkg::ACT_CLEAR, 16'd0, 16'd0, 16'd1, 10'd0);
    endtask

    task automatic test_random();
        int          target;
        int          n_adds;
        int          n_reads;
        logic [15:0] key;
        logic [15:0] score;
        logic [15:0] w;
        int unsigned k;
        target = sent_count + RANDOM_ITEMS;
        while (sent_count < target) begin
            if ($urandom_range(3) == 0)
                send_request(ipc_pkg::ACT_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom),
                             10'($urandom));
            key = 16'($urandom_range(20000));
            n_adds = $urandom_range(1, 40);
            for (int i = 0; i < n_adds; i++) begin
                k = key + $urandom_range(0, 200);
                if ($urandom_range(9) == 0) k = $urandom_range(32768);   // break the order
                key = (k > 32768) ? 16'd32768 : 16'(k);
                score = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(32768));
                case ($urandom_range(19))
                    0:       w = 16'd0;
                    1:       w = 16'hFFFF;
                    2:       w = 16'($urandom);
                    default: w = 16'($urandom_range(1, 200));
                endcase
                send_request(ipc_pkg::ACT_ADD, key, score, w, 10'($urandom));
            end
            if ($urandom_range(7) != 0)
                send_request(ipc_pkg::ACT_FINISH, 16'($urandom), 16'($urandom), 16'($urandom),
                             10'($urandom));
            n_reads = $urandom_range(1, 8);
            for (int i = 0; i < n_reads; i++) begin
                case ($urandom_range(9))
                    0:       send_request(ipc_pkg::ACT_READ, 16'($urandom), 16'($urandom),
                                          16'($urandom), 10'($urandom));
                    1, 2, 3: send_request(ipc_pkg::ACT_READ, 16'($urandom), 16'($urandom),
                                          16'($urandom),
                                          10'($urandom_range(blk_top > 0 ? blk_top - 1 : 0)));
                    4:       send_request(3'($urandom_range(5, 7)), 16'($urandom),
                                          16'($urandom), 16'($urandom), 10'($urandom));
                    5:       send_request(ipc_pkg::ACT_QUERY, 16'($urandom), 16'($urandom),
                                          16'($urandom), 10'($urandom));
                    default: send_request(ipc_pkg::ACT_QUERY, 16'($urandom_range(32768)),
                                          16'($urandom), 16'($urandom), 10'($urandom));
                endcase
            end
        end
    endtask

    initial begin
        calib_clear();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_capacity();
        test_random();
        i_valid <= 1'b0;
        while (calib_expected.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
